>>> src/vfspi_pkg.sv
// Package: format ROM, packet types and constants for the video format SPI sender.
`timescale 1ns / 1ps

package vfspi_pkg;

  localparam int FORMAT_COUNT = 22;
  localparam int PACKET_BITS  = 64;
  localparam int BIT_CNT_W    = $clog2(PACKET_BITS);

  localparam int GEN_W   = 2;
  localparam int IDX_W   = 5;
  localparam int DELAY_W = 26;
  localparam int SPL_W   = 10;
  localparam int LPF_W   = 11;

  typedef logic [GEN_W-1:0]       gen_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [DELAY_W-1:0]     delay_t;
  typedef logic [PACKET_BITS-1:0] packet_t;
  typedef logic [BIT_CNT_W-1:0]   bit_cnt_t;

  typedef struct packed {
    logic [SPL_W-1:0] spl;
    logic [LPF_W-1:0] lpf;
    logic             clk;
    logic             scan;
    logic [1:0]       sync;
  } fmt_row_t;

  typedef struct packed {
    packet_t bits;
    logic    led;
  } pkt_word_t;

  function automatic fmt_row_t fmt_rom(input idx_t idx);
    fmt_row_t r;
    r = '{spl: 10'd1, lpf: 11'd1125, clk: 1'b0, scan: 1'b0, sync: 2'd0};
    case (idx)
      5'd1:  r = '{spl: 10'd200, lpf: 11'd1125, clk: 1'b0, scan: 1'b0, sync: 2'd0};
      5'd2:  r = '{spl: 10'd200, lpf: 11'd1125, clk: 1'b1, scan: 1'b0, sync: 2'd3};
      5'd3:  r = '{spl: 10'd240, lpf: 11'd1125, clk: 1'b0, scan: 1'b0, sync: 2'd2};
      5'd4:  r = '{spl: 10'd400, lpf: 11'd1125, clk: 1'b0, scan: 1'b1, sync: 2'd0};
      5'd5:  r = '{spl: 10'd400, lpf: 11'd1125, clk: 1'b1, scan: 1'b1, sync: 2'd3};
      5'd6:  r = '{spl: 10'd480, lpf: 11'd1125, clk: 1'b0, scan: 1'b1, sync: 2'd2};
      5'd7:  r = '{spl: 10'd400, lpf: 11'd1125, clk: 1'b0, scan: 1'b0, sync: 2'd0};
      5'd8:  r = '{spl: 10'd400, lpf: 11'd1125, clk: 1'b1, scan: 1'b0, sync: 2'd3};
      5'd9:  r = '{spl: 10'd480, lpf: 11'd1125, clk: 1'b0, scan: 1'b0, sync: 2'd2};
      5'd10: r = '{spl: 10'd500, lpf: 11'd1125, clk: 1'b0, scan: 1'b0, sync: 2'd0};
      5'd11: r = '{spl: 10'd500, lpf: 11'd1125, clk: 1'b1, scan: 1'b0, sync: 2'd0};
      5'd12: r = '{spl: 10'd400, lpf: 11'd1125, clk: 1'b0, scan: 1'b1, sync: 2'd0};
      5'd13: r = '{spl: 10'd400, lpf: 11'd1125, clk: 1'b1, scan: 1'b1, sync: 2'd3};
      5'd14: r = '{spl: 10'd330, lpf: 11'd750,  clk: 1'b0, scan: 1'b0, sync: 2'd0};
      5'd15: r = '{spl: 10'd330, lpf: 11'd750,  clk: 1'b1, scan: 1'b0, sync: 2'd3};
      5'd16: r = '{spl: 10'd396, lpf: 11'd750,  clk: 1'b0, scan: 1'b0, sync: 2'd2};
      5'd17: r = '{spl: 10'd660, lpf: 11'd750,  clk: 1'b0, scan: 1'b0, sync: 2'd0};
      5'd18: r = '{spl: 10'd660, lpf: 11'd750,  clk: 1'b1, scan: 1'b0, sync: 2'd3};
      5'd19: r = '{spl: 10'd792, lpf: 11'd750,  clk: 1'b0, scan: 1'b0, sync: 2'd2};
      5'd20: r = '{spl: 10'd825, lpf: 11'd750,  clk: 1'b0, scan: 1'b0, sync: 2'd0};
      5'd21: r = '{spl: 10'd825, lpf: 11'd750,  clk: 1'b1, scan: 1'b0, sync: 2'd0};
      default: r = '{spl: 10'd1, lpf: 11'd1125, clk: 1'b0, scan: 1'b0, sync: 2'd0};
    endcase
    return r;
  endfunction

endpackage

>>> src/vfspi_pack.sv
// Packet builder: format lookup and 64-bit packet assembly.
`timescale 1ns / 1ps

module vfspi_pack (
  input  vfspi_pkg::idx_t      format_index,
  input  vfspi_pkg::delay_t    delay_samples,
  output vfspi_pkg::pkt_word_t pkt
);
  import vfspi_pkg::*;

  idx_t             row_idx;
  fmt_row_t         row;
  logic [SPL_W-1:0] spl_m1;
  logic [LPF_W-1:0] lpf_m1;

  always_comb begin
    row_idx = ({1'b0, format_index} < (IDX_W+1)'(FORMAT_COUNT)) ? format_index : '0;
    row     = fmt_rom(row_idx);
    spl_m1  = row.spl - SPL_W'(1);
    lpf_m1  = row.lpf - LPF_W'(1);
    pkt.led = (row.spl == SPL_W'(1));
    pkt.bits = {6'd0, delay_samples,
                1'b0, row.clk, row.sync, 2'b00, spl_m1,
                3'b000, row.scan, 1'b0, lpf_m1};
  end

endmodule

>>> src/vfspi_shift.sv
// Output shifter: holds one packet and sends it MSB first, one bit per word.
`timescale 1ns / 1ps

module vfspi_shift (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  vfspi_pkg::gen_t      load_gen,
  input  vfspi_pkg::pkt_word_t load_pkt,
  output logic                 busy,
  output logic                 done,
  output vfspi_pkg::gen_t      out_chip_select,
  output logic                 out_serial_bit,
  output logic                 out_led_on,
  output logic                 out_last_bit,
  output logic                 out_valid,
  input  logic                 out_stall
);
  import vfspi_pkg::*;

  logic     busy_r, busy_nxt;
  bit_cnt_t cnt_r, cnt_nxt;
  packet_t  sr_r, sr_nxt;
  gen_t     gen_r, gen_nxt;
  logic     led_r, led_nxt;
  logic     last;
  logic     take;

  assign last = (cnt_r == BIT_CNT_W'(PACKET_BITS-1));
  assign take = busy_r && !out_stall;
  assign done = take && last;
  assign busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sr_nxt   = sr_r;
    gen_nxt  = gen_r;
    led_nxt  = led_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sr_nxt   = load_pkt.bits;
      gen_nxt  = load_gen;
      led_nxt  = load_pkt.led;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + BIT_CNT_W'(1);
        sr_nxt  = {sr_r[PACKET_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sr_r  <= sr_nxt;
    gen_r <= gen_nxt;
    led_r <= led_nxt;
  end

  assign out_valid       = busy_r;
  assign out_chip_select = gen_r;
  assign out_serial_bit  = sr_r[PACKET_BITS-1];
  assign out_led_on      = led_r;
  assign out_last_bit    = last;

endmodule

>>> src/video_format_spi_packet_sender.sv
// Top level: request register, packet builder and bit shifter.
// The request word is registered, then loaded into the shifter register, whose MSB is the first bit shown.
// Output: 64 output words per request, one bit each from the single-bit shifter.
// The next request waits in the input register and loads in the cycle the
// last bit is taken.
// Reset: synchronous active-low rst_n clears the valid flags; no words pending.
`timescale 1ns / 1ps

module video_format_spi_packet_sender (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vfspi_pkg::gen_t       in_generator,
  input  vfspi_pkg::idx_t       in_format_index,
  input  vfspi_pkg::delay_t     in_delay_samples,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vfspi_pkg::gen_t       out_chip_select,
  output logic                  out_serial_bit,
  output logic                  out_led_on,
  output logic                  out_last_bit
);
  import vfspi_pkg::*;

  logic      req_vld_r, req_vld_nxt;
  gen_t      gen_r;
  idx_t      idx_r;
  delay_t    delay_r;
  pkt_word_t pkt;
  logic      busy;
  logic      done;
  logic      load;
  logic      in_take;

  assign load     = req_vld_r && (!busy || done);
  assign in_stall = req_vld_r && !load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (in_take) begin
      req_vld_nxt = 1'b1;
    end else if (load) begin
      req_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
    if (in_take) begin
      gen_r   <= in_generator;
      idx_r   <= in_format_index;
      delay_r <= in_delay_samples;
    end
  end

  vfspi_pack u_pack (
    .format_index  (idx_r),
    .delay_samples (delay_r),
    .pkt           (pkt)
  );

  vfspi_shift u_shift (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .load_gen        (gen_r),
    .load_pkt        (pkt),
    .busy            (busy),
    .done            (done),
    .out_chip_select (out_chip_select),
    .out_serial_bit  (out_serial_bit),
    .out_led_on      (out_led_on),
    .out_last_bit    (out_last_bit),
    .out_valid       (out_valid),
    .out_stall       (out_stall)
  );

endmodule

>>> src/vfspi_checker.sv
// Port checker for the video format SPI sender, bound to the top level.
`timescale 1ns / 1ps

module vfspi_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input vfspi_pkg::gen_t       out_chip_select,
  input logic                  out_serial_bit,
  input logic                  out_led_on,
  input logic                  out_last_bit
);
  import vfspi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_serial_bit)
      && $stable(out_last_bit))
    else $error("stalled output word changed");

  a_packet_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_bit |=> out_valid)
    else $error("gap inside a packet");

  a_packet_tags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_bit |=>
      out_chip_select == $past(out_chip_select) && out_led_on == $past(out_led_on))
    else $error("select or led changed inside a packet");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted request did not start");

endmodule

bind video_format_spi_packet_sender vfspi_checker u_vfspi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_chip_select (out_chip_select),
  .out_serial_bit  (out_serial_bit),
  .out_led_on      (out_led_on),
  .out_last_bit    (out_last_bit)
);

>>> bench/tb_video_format_spi_packet_sender.sv
// Testbench: random and directed format requests, bit-by-bit check of the SPI packet stream.
`timescale 1ns / 1ps

module tb_video_format_spi_packet_sender;
  import vfspi_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 370;
  localparam int HOLD_AFTER     = 2000;
  localparam int HOLD_CYCLES    = 800;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  class spi_bit_scoreboard;
    typedef struct {
      logic [GEN_W-1:0] cs;
      logic             mosi;
      logic             led;
      logic             last;
    } spi_bit_t;

    typedef struct {
      logic [SPL_W-1:0] spl;
      logic [LPF_W-1:0] lpf;
      logic             clk;
      logic             scan;
      logic [1:0]       sync;
    } vfmt_t;

    spi_bit_t bits_q[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    function vfmt_t lookup_format(idx_t idx);
      vfmt_t f;
      int    row;
      row = (idx >= FORMAT_COUNT) ? 0 : int'(idx);
      case (row)
        1:  f = '{10'd200, 11'd1125, 1'b0, 1'b0, 2'd0};
        2:  f = '{10'd200, 11'd1125, 1'b1, 1'b0, 2'd3};
        3:  f = '{10'd240, 11'd1125, 1'b0, 1'b0, 2'd2};
        4:  f = '{10'd400, 11'd1125, 1'b0, 1'b1, 2'd0};
        5:  f = '{10'd400, 11'd1125, 1'b1, 1'b1, 2'd3};
        6:  f = '{10'd480, 11'd1125, 1'b0, 1'b1, 2'd2};
        7:  f = '{10'd400, 11'd1125, 1'b0, 1'b0, 2'd0};
        8:  f = '{10'd400, 11'd1125, 1'b1, 1'b0, 2'd3};
        9:  f = '{10'd480, 11'd1125, 1'b0, 1'b0, 2'd2};
        10: f = '{10'd500, 11'd1125, 1'b0, 1'b0, 2'd0};
        11: f = '{10'd500, 11'd1125, 1'b1, 1'b0, 2'd0};
        12: f = '{10'd400, 11'd1125, 1'b0, 1'b1, 2'd0};
        13: f = '{10'd400, 11'd1125, 1'b1, 1'b1, 2'd3};
        14: f = '{10'd330, 11'd750, 1'b0, 1'b0, 2'd0};
        15: f = '{10'd330, 11'd750, 1'b1, 1'b0, 2'd3};
        16: f = '{10'd396, 11'd750, 1'b0, 1'b0, 2'd2};
        17: f = '{10'd660, 11'd750, 1'b0, 1'b0, 2'd0};
        18: f = '{10'd660, 11'd750, 1'b1, 1'b0, 2'd3};
        19: f = '{10'd792, 11'd750, 1'b0, 1'b0, 2'd2};
        20: f = '{10'd825, 11'd750, 1'b0, 1'b0, 2'd0};
        21: f = '{10'd825, 11'd750, 1'b1, 1'b0, 2'd0};
        default: f = '{10'd1, 11'd1125, 1'b0, 1'b0, 2'd0};
      endcase
      return f;
    endfunction

    function void note_request(gen_t gen, idx_t idx, delay_t delay);
      vfmt_t            f;
      logic [SPL_W-1:0] spl_m1;
      logic [LPF_W-1:0] lpf_m1;
      packet_t          pkt;
      spi_bit_t         b;
      f      = lookup_format(idx);
      spl_m1 = f.spl - 1'b1;
      lpf_m1 = f.lpf - 1'b1;
      pkt = {6'b0, delay,
             1'b0, f.clk, f.sync, 2'b00, spl_m1[9:8],
             spl_m1[7:0],
             3'b000, f.scan, 1'b0, lpf_m1[10:8],
             lpf_m1[7:0]};
      for (int k = 0; k < PACKET_BITS; k++) begin
        b.cs   = gen;
        b.mosi = pkt[PACKET_BITS-1-k];
        b.led  = (f.spl == 1);
        b.last = (k == PACKET_BITS - 1);
        bits_q.push_back(b);
      end
    endfunction

    function void check_bit(logic [GEN_W-1:0] cs, logic mosi, logic led, logic last);
      spi_bit_t e;
      if (bits_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: cs=%0d mosi=%b led=%b last=%b", cs, mosi, led, last);
        return;
      end
      e = bits_q.pop_front();
      if (cs !== e.cs || mosi !== e.mosi || led !== e.led || last !== e.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch at %0t: expected cs=%0d mosi=%b led=%b last=%b, ",
                    "got cs=%0d mosi=%b led=%b last=%b"},
                   $realtime, e.cs, e.mosi, e.led, e.last, cs, mosi, led, last);
      end
    endfunction

    function int pending();
      return bits_q.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  gen_t   in_generator = '0;
  idx_t   in_format_index = '0;
  delay_t in_delay_samples = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  gen_t   out_chip_select;
  logic   out_serial_bit;
  logic   out_led_on;
  logic   out_last_bit;

  spi_bit_scoreboard sb = new();

  video_format_spi_packet_sender u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_generator     (in_generator),
    .in_format_index  (in_format_index),
    .in_delay_samples (in_delay_samples),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chip_select  (out_chip_select),
    .out_serial_bit   (out_serial_bit),
    .out_led_on       (out_led_on),
    .out_last_bit     (out_last_bit)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 150);
  endfunction

  task automatic send_word(gen_t g, idx_t i, delay_t d, int gap);
    in_valid         <= 1'b1;
    in_generator     <= g;
    in_format_index  <= i;
    in_delay_samples <= d;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(g, i, d);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic delay_t pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return delay_t'($urandom());
  endfunction

  // receiver: random stalls, calm windows, one long hold-off
  initial begin
    int cyc;
    int seen;
    int stall_left;
    int g;
    bit held;
    cyc        = 0;
    seen       = 0;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_valid && !out_stall) begin
        sb.check_bit(out_chip_select, out_serial_bit, out_led_on, out_last_bit);
        seen++;
      end
      if (!held && seen >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ((cyc % 3000) < 400) begin
        out_stall <= 1'b0;
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall  <= 1'b1;
          stall_left = g - 1;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle = 0;
      else
        idle++;
    end
    $display("tb_video_format_spi_packet_sender NOT OK");
    $finish;
  end

  initial begin
    gen_t   g;
    idx_t   i;
    delay_t d;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every ROM row, delay extremes and patterns, out-of-range indices
    for (int n = 0; n < FORMAT_COUNT; n++) begin
      case (n)
        0:       d = '0;
        1:       d = '1;
        2:       d = 26'h2AAAAAA;
        3:       d = 26'h1555555;
        4:       d = 26'h2000000;
        5:       d = 26'h0000001;
        default: d = delay_t'($urandom());
      endcase
      send_word(gen_t'(n % 4), idx_t'(n), d, gap_len());
    end
    send_word(gen_t'(3), idx_t'(FORMAT_COUNT), '1, gap_len());
    send_word(gen_t'(0), '1, 26'h2AAAAAA, 0);
    send_word(gen_t'(2), idx_t'(26), '0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      g = gen_t'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 8)
        i = idx_t'($urandom_range(0, FORMAT_COUNT - 1));
      else
        i = idx_t'($urandom_range(FORMAT_COUNT, 31));
      d = pick_delay();
      send_word(g, i, d, ((n % 60) < 15) ? 0 : gap_len());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_video_format_spi_packet_sender OK");
    else
      $display("tb_video_format_spi_packet_sender NOT OK");
    $finish;
  end

endmodule
